FILE: hw/rtl/lsmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsmt_pkg;

    typedef struct packed {
        logic       display_enable;
        logic [7:0] lyc;
        logic [3:0] stat_enables;
        logic [7:0] window_y;
    } item_t;

    typedef struct packed {
        logic [1:0] stat_mode;
        logic       coincidence;
        logic [7:0] line_number;
        logic       stat_irq;
        logic       vblank_irq;
        logic       oam_scan_start;
        logic       line_render;
        logic       window_line_hit;
    } result_t;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } mode_t;

    localparam logic [8:0] DOT_STEP  = 9'd4;
    localparam logic [8:0] OAM_DOTS  = 9'd80;
    localparam logic [8:0] XFER_DOTS = 9'd172;
    localparam logic [8:0] HBL_DOTS  = 9'd204;
    localparam logic [8:0] LINE_DOTS = 9'd456;
    localparam logic [7:0] VBL_LINE  = 8'd144;
    localparam logic [7:0] LAST_LINE = 8'd153;

    localparam int EN_HBL_BIT = 0;
    localparam int EN_VBL_BIT = 1;
    localparam int EN_OAM_BIT = 2;
    localparam int EN_LYC_BIT = 3;

    localparam int STAT_COINC_BIT = 2;

    // status interrupt line level for the given enables, status bits and mode
    function automatic logic line_high(
        input logic [3:0] en,
        input logic [2:0] status,
        input mode_t      mode
    );
        logic high;
        high = (en[EN_LYC_BIT] && status[STAT_COINC_BIT])
            || (en[EN_OAM_BIT] && (mode == MODE_OAM))
            || (en[EN_VBL_BIT] && (mode == MODE_VBLANK))
            || (en[EN_HBL_BIT] && (mode == MODE_HBLANK));
        return high;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lsmt_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module lsmt_in_reg
    import lsmt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_ready,
    input  wire item_t item,
    output logic       step_valid,
    input  wire logic  step_ready,
    output item_t      step
);

    logic  valid_reg;
    logic  valid_next;
    item_t data_reg;

    assign item_ready = !valid_reg || step_ready;
    assign valid_next = item_valid || (valid_reg && !step_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            data_reg <= item;
        end
    end

    assign step_valid = valid_reg;
    assign step       = data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/lsmt_timer.sv
`timescale 1ns / 1ps
`default_nettype none

module lsmt_timer
    import lsmt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  step_valid,
    output logic       step_ready,
    input  wire item_t step,
    output logic       result_valid,
    input  wire logic  result_ready,
    output result_t    result
);

    mode_t      mode_reg;
    mode_t      mode_next;
    logic [8:0] dot_reg;
    logic [8:0] dot_next;
    logic [7:0] line_reg;
    logic [7:0] line_next;
    logic [2:0] status_reg;
    logic [2:0] status_next;
    logic       window_reg;
    logic       window_next;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    out_next;
    logic       advance;

    logic [8:0] dot_inc;
    logic [7:0] line_inc;
    logic       hit_inc;
    logic [2:0] status_adv;
    logic       sirq;
    logic       virq;
    logic       oam_start;
    logic       render;
    logic [3:0] en;

    assign step_ready = !out_valid_reg || result_ready;
    assign advance    = step_valid && step_ready;
    assign en         = step.stat_enables;

    always_comb
    begin
        mode_next   = mode_reg;
        dot_next    = dot_reg;
        line_next   = line_reg;
        status_next = status_reg;
        window_next = window_reg;
        sirq        = 1'b0;
        virq        = 1'b0;
        oam_start   = 1'b0;
        render      = 1'b0;
        dot_inc     = dot_reg + DOT_STEP;
        line_inc    = line_reg + 8'd1;
        hit_inc     = (line_inc == step.lyc);
        status_adv  = status_reg;
        status_adv[STAT_COINC_BIT] = status_reg[STAT_COINC_BIT] || hit_inc;

        if (!step.display_enable)
        begin
            mode_next      = MODE_HBLANK;
            dot_next       = '0;
            line_next      = '0;
            status_next[0] = 1'b0;
        end
        else
        begin
            dot_next = dot_inc;
            case (mode_reg)
                MODE_OAM:
                begin
                    if (dot_inc >= OAM_DOTS)
                    begin
                        oam_start = 1'b1;
                        dot_next  = '0;
                        mode_next = MODE_XFER;
                    end
                end
                MODE_XFER:
                begin
                    if (dot_inc >= XFER_DOTS)
                    begin
                        dot_next  = '0;
                        sirq      = !line_high(en, status_reg, mode_reg) && en[EN_HBL_BIT];
                        mode_next = MODE_HBLANK;
                        render    = 1'b1;
                    end
                end
                MODE_HBLANK:
                begin
                    if (dot_inc >= HBL_DOTS)
                    begin
                        dot_next  = '0;
                        line_next = line_inc;
                        sirq      = !line_high(en, status_reg, mode_reg) && hit_inc
                                    && en[EN_LYC_BIT];
                        if (line_inc == step.window_y)
                        begin
                            window_next = 1'b1;
                        end
                        if (line_inc == VBL_LINE)
                        begin
                            sirq = sirq || (!line_high(en, status_adv, mode_reg)
                                   && (en[EN_VBL_BIT] || en[EN_OAM_BIT]));
                            mode_next = MODE_VBLANK;
                            virq      = 1'b1;
                        end
                        else
                        begin
                            sirq = sirq || (!line_high(en, status_adv, mode_reg)
                                   && en[EN_OAM_BIT]);
                            mode_next = MODE_OAM;
                        end
                    end
                end
                default:
                begin
                    window_next = 1'b0;
                    if (dot_inc >= LINE_DOTS)
                    begin
                        dot_next  = '0;
                        line_next = line_inc;
                        sirq      = !line_high(en, status_reg, mode_reg) && hit_inc
                                    && en[EN_LYC_BIT];
                        if (line_inc > LAST_LINE)
                        begin
                            sirq = sirq || (!line_high(en, status_adv, mode_reg)
                                   && en[EN_OAM_BIT]);
                            mode_next = MODE_OAM;
                            line_next = '0;
                            if (step.window_y == 8'd0)
                            begin
                                window_next = 1'b1;
                            end
                        end
                    end
                end
            endcase
            status_next = {line_next == step.lyc, mode_next};
        end

        out_next.stat_mode       = status_next[1:0];
        out_next.coincidence     = status_next[STAT_COINC_BIT];
        out_next.line_number     = line_next;
        out_next.stat_irq        = sirq;
        out_next.vblank_irq      = virq;
        out_next.oam_scan_start  = oam_start;
        out_next.line_render     = render;
        out_next.window_line_hit = window_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_HBLANK;
            dot_reg       <= '0;
            line_reg      <= '0;
            status_reg    <= '0;
            window_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                mode_reg   <= mode_next;
                dot_reg    <= dot_next;
                line_reg   <= line_next;
                status_reg <= status_next;
                window_reg <= window_next;
            end
            if (step_ready)
            begin
                out_valid_reg <= step_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef NO_ASSERTIONS
    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg <= LAST_LINE)
        else $error("line counter beyond last line");

    a_vblank_lines: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_VBLANK) == (line_reg >= VBL_LINE))
        else $error("vblank mode and line counter disagree");

    a_dot_range: assert property (@(posedge clk) disable iff (!rst_n)
        dot_reg < LINE_DOTS)
        else $error("dot counter beyond line length");

    a_vblank_irq_line: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.vblank_irq) |->
        (out_reg.line_number == VBL_LINE && out_reg.stat_mode == MODE_VBLANK))
        else $error("vblank interrupt off line 144");

    a_single_event: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> $onehot0({out_reg.vblank_irq, out_reg.oam_scan_start,
                              out_reg.line_render}))
        else $error("more than one mode event in one beat");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/lcd_scanline_mode_timer.sv
// LCD scanline mode timer: one tick beat in, one status beat out, at a sustained rate of one
// beat per clock while result_ready stays high. Each tick is captured in an input register,
// and the mode, dot and line counters update in a single combinational pass into the result
// register, so a tick passes the input register and then the result register before
// result_valid rises. Both registers stall on result_ready: while a finished result waits, the
// input register still takes one more tick, and later ticks wait until that result is taken.
`timescale 1ns / 1ps
`default_nettype none

module lcd_scanline_mode_timer
    import lsmt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_ready,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result
);

    logic  step_valid;
    logic  step_ready;
    item_t step;

    lsmt_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .step_valid (step_valid),
        .step_ready (step_ready),
        .step       (step)
    );

    lsmt_timer u_timer (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_valid   (step_valid),
        .step_ready   (step_ready),
        .step         (step),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lsmt_pkg::*;

    typedef struct packed {
        item_t   tick;
        logic    typed;
        result_t want;
    } plan_row_t;

    localparam plan_row_t PLAN [18] = '{
        '{tick: '{1'b0, 8'd0, 4'hF, 8'd0}, typed: 1'b1, want: '0},
        '{tick: '{1'b0, 8'd255, 4'h0, 8'd255}, typed: 1'b1, want: '0},
        '{tick: '{1'b1, 8'd0, 4'h0, 8'd0}, typed: 1'b1,
            want: '{stat_mode: MODE_HBLANK, coincidence: 1'b1, default: '0}},
        // display off keeps the coincidence bit
        '{tick: '{1'b0, 8'd255, 4'hF, 8'd255}, typed: 1'b1,
            want: '{stat_mode: MODE_HBLANK, coincidence: 1'b1, default: '0}},
        '{tick: '{1'b1, 8'd255, 4'hF, 8'd0}, typed: 1'b0, want: '0},
        '{tick: '{1'b1, 8'd0, 4'h1, 8'd255}, typed: 1'b0, want: '0},
        '{tick: '{1'b1, 8'd1, 4'h2, 8'd1}, typed: 1'b0, want: '0},
        '{tick: '{1'b1, 8'd0, 4'h4, 8'd0}, typed: 1'b0, want: '0},
        '{tick: '{1'b1, 8'd128, 4'h8, 8'd128}, typed: 1'b0, want: '0},
        '{tick: '{1'b1, 8'd85, 4'h5, 8'd170}, typed: 1'b0, want: '0},
        '{tick: '{1'b1, 8'd170, 4'hA, 8'd85}, typed: 1'b0, want: '0},
        '{tick: '{1'b1, 8'd255, 4'h0, 8'd255}, typed: 1'b0, want: '0},
        '{tick: '{1'b0, 8'd0, 4'hF, 8'd0}, typed: 1'b0, want: '0},
        '{tick: '{1'b1, 8'd1, 4'h8, 8'd1}, typed: 1'b0, want: '0},
        '{tick: '{1'b1, 8'd0, 4'h3, 8'd254}, typed: 1'b0, want: '0},
        '{tick: '{1'b1, 8'd254, 4'hC, 8'd1}, typed: 1'b0, want: '0},
        '{tick: '{1'b1, 8'd127, 4'h9, 8'd127}, typed: 1'b0, want: '0},
        '{tick: '{1'b1, 8'd0, 4'h6, 8'd0}, typed: 1'b0, want: '0}
    };

    logic    clk;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    // timing state mirrored by the predictor
    mode_t      lcd_mode;
    logic [8:0] dots;
    logic [7:0] ly;
    logic [2:0] stat_bits;
    logic       win_hit;

    result_t expected_status [$];
    int      mismatch_count = 0;
    int      beat_index = 0;
    bit      tx_steady = 1'b0;
    bit      rx_steady = 1'b0;

    lcd_scanline_mode_timer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("[lcd_scanline_mode_timer] ERROR");
        $finish;
    end

    function automatic logic stat_line_low(logic [3:0] en);
        logic asserted;
        asserted = (en[EN_LYC_BIT] && stat_bits[STAT_COINC_BIT])
            || (en[EN_OAM_BIT] && lcd_mode == MODE_OAM)
            || (en[EN_VBL_BIT] && lcd_mode == MODE_VBLANK)
            || (en[EN_HBL_BIT] && lcd_mode == MODE_HBLANK);
        return !asserted;
    endfunction

    function automatic logic advance_line(logic [3:0] en, logic [7:0] lyc);
        logic irq;
        dots = '0;
        ly = ly + 8'd1;
        irq = stat_line_low(en) && ly == lyc && en[EN_LYC_BIT];
        if (ly == lyc)
            stat_bits[STAT_COINC_BIT] = 1'b1;
        return irq;
    endfunction

    function automatic result_t predict_tick(item_t t);
        result_t r;
        logic [3:0] en;
        r = '0;
        en = t.stat_enables;
        if (!t.display_enable)
        begin
            lcd_mode = MODE_HBLANK;
            dots = '0;
            ly = '0;
            stat_bits[0] = 1'b0;
        end
        else
        begin
            dots = dots + DOT_STEP;
            case (lcd_mode)
                MODE_OAM:
                begin
                    if (dots >= OAM_DOTS)
                    begin
                        r.oam_scan_start = 1'b1;
                        dots = '0;
                        lcd_mode = MODE_XFER;
                    end
                end
                MODE_XFER:
                begin
                    if (dots >= XFER_DOTS)
                    begin
                        dots = '0;
                        if (stat_line_low(en) && en[EN_HBL_BIT])
                            r.stat_irq = 1'b1;
                        lcd_mode = MODE_HBLANK;
                        r.line_render = 1'b1;
                    end
                end
                MODE_HBLANK:
                begin
                    if (dots >= HBL_DOTS)
                    begin
                        if (advance_line(en, t.lyc))
                            r.stat_irq = 1'b1;
                        if (ly == t.window_y)
                            win_hit = 1'b1;
                        if (ly == VBL_LINE)
                        begin
                            if (stat_line_low(en) && (en[EN_VBL_BIT] || en[EN_OAM_BIT]))
                                r.stat_irq = 1'b1;
                            lcd_mode = MODE_VBLANK;
                            r.vblank_irq = 1'b1;
                        end
                        else
                        begin
                            if (stat_line_low(en) && en[EN_OAM_BIT])
                                r.stat_irq = 1'b1;
                            lcd_mode = MODE_OAM;
                        end
                    end
                end
                default:
                begin
                    win_hit = 1'b0;
                    if (dots >= LINE_DOTS)
                    begin
                        if (advance_line(en, t.lyc))
                            r.stat_irq = 1'b1;
                        // line wraps after counting one past the last
                        if (ly > LAST_LINE)
                        begin
                            if (stat_line_low(en) && en[EN_OAM_BIT])
                                r.stat_irq = 1'b1;
                            lcd_mode = MODE_OAM;
                            ly = '0;
                            if (ly == t.window_y)
                                win_hit = 1'b1;
                        end
                    end
                end
            endcase
            stat_bits = {ly == t.lyc, lcd_mode};
        end
        r.stat_mode = stat_bits[1:0];
        r.coincidence = stat_bits[STAT_COINC_BIT];
        r.line_number = ly;
        r.window_line_hit = win_hit;
        return r;
    endfunction

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        $display("mismatch %s at beat %0d: got %0h want %0h", field, beat_index, got, want);
        mismatch_count++;
    endtask

    task automatic check_status(result_t got);
        result_t want;
        if (expected_status.size() == 0)
        begin
            report_mismatch("unexpected beat", 32'(got), 0);
        end
        else
        begin
            want = expected_status.pop_front();
            if (got.stat_mode !== want.stat_mode)
                report_mismatch("stat_mode", 32'(got.stat_mode), 32'(want.stat_mode));
            if (got.coincidence !== want.coincidence)
                report_mismatch("coincidence", 32'(got.coincidence),
                                32'(want.coincidence));
            if (got.line_number !== want.line_number)
                report_mismatch("line_number", 32'(got.line_number),
                                32'(want.line_number));
            if (got.stat_irq !== want.stat_irq)
                report_mismatch("stat_irq", 32'(got.stat_irq), 32'(want.stat_irq));
            if (got.vblank_irq !== want.vblank_irq)
                report_mismatch("vblank_irq", 32'(got.vblank_irq), 32'(want.vblank_irq));
            if (got.oam_scan_start !== want.oam_scan_start)
                report_mismatch("oam_scan_start", 32'(got.oam_scan_start),
                                32'(want.oam_scan_start));
            if (got.line_render !== want.line_render)
                report_mismatch("line_render", 32'(got.line_render),
                                32'(want.line_render));
            if (got.window_line_hit !== want.window_line_hit)
                report_mismatch("window_line_hit", 32'(got.window_line_hit),
                                32'(want.window_line_hit));
        end
        beat_index++;
    endtask

    task automatic send_tick(item_t t, logic typed, result_t want);
        int gap;
        result_t predicted;
        if ($urandom_range(0, 63) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= t;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predicted = predict_tick(t);
        expected_status.push_back(typed ? want : predicted);
    endtask

    task automatic wait_for_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_status.size() != 0);
    endtask

    // result side
    initial begin
        int stall;
        int beats;
        beats = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 4);
            // long hold so the block backs up into its input
            if (beats == 40 || beats == 600)
                stall = 48;
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            check_status(result);
            beats++;
        end
    end

    initial begin
        item_t t;
        lcd_mode = MODE_HBLANK;
        dots = '0;
        ly = '0;
        stat_bits = '0;
        win_hit = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[i])
            send_tick(PLAN[i].tick, PLAN[i].typed, PLAN[i].want);
        wait_for_results();

        // random fields, lyc and window_y often near the current line, and rare display off
        repeat (1032)
        begin
            t.display_enable = ($urandom_range(0, 199) != 0);
            t.lyc = $urandom_range(0, 1) ? ly + 8'($urandom_range(0, 1)) : 8'($urandom);
            t.stat_enables = 4'($urandom);
            t.window_y = $urandom_range(0, 1) ? ly + 8'($urandom_range(0, 1))
                                              : 8'($urandom);
            send_tick(t, 1'b0, '0);
        end

        wait_for_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("[lcd_scanline_mode_timer] OK");
        else
            $display("[lcd_scanline_mode_timer] ERROR");
        $finish;
    end

endmodule
